// ===== sv/hpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex pixel LED mapper package
// Shared constants, register indexes and the fixed 16-entry color palette.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpl_pkg;

  // Default matrix size of one frame.
  localparam int DEF_MATRIX_W = 16;
  localparam int DEF_MATRIX_H = 16;

  // Widths fixed by the item fields and the position state.
  localparam int CHAR_W  = 8;
  localparam int LED_W   = 8;
  localparam int COLOR_W = 8;
  localparam int FRAME_W = 2;
  localparam int POS_W   = 5;
  localparam int COORD_W = 4;
  localparam int DIGIT_W = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLIP_H    = 2'd0,
    REG_FLIP_V    = 2'd1,
    REG_SERPENT   = 2'd2,
    REG_QUADRANT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  // ASCII hex digit decode; other bytes fold into four bits by the same rule.
  function automatic logic [DIGIT_W-1:0] decode_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    begin
      if (c >= 8'd97) begin
        d = c - 8'd87;
      end else if (c >= 8'd65) begin
        d = c - 8'd55;
      end else begin
        d = c - 8'd48;
      end
      return d[DIGIT_W-1:0];
    end
  endfunction

  // Fixed 16-entry palette.
  function automatic rgb_t palette(input logic [DIGIT_W-1:0] idx);
    rgb_t p;
    begin
      case (idx)
        4'd0:    p = '{8'd0,   8'd0,   8'd0};
        4'd1:    p = '{8'd29,  8'd43,  8'd83};
        4'd2:    p = '{8'd126, 8'd37,  8'd83};
        4'd3:    p = '{8'd0,   8'd135, 8'd81};
        4'd4:    p = '{8'd171, 8'd82,  8'd54};
        4'd5:    p = '{8'd95,  8'd87,  8'd79};
        4'd6:    p = '{8'd194, 8'd195, 8'd199};
        4'd7:    p = '{8'd255, 8'd241, 8'd232};
        4'd8:    p = '{8'd255, 8'd0,   8'd77};
        4'd9:    p = '{8'd255, 8'd163, 8'd0};
        4'd10:   p = '{8'd255, 8'd236, 8'd39};
        4'd11:   p = '{8'd0,   8'd228, 8'd54};
        4'd12:   p = '{8'd41,  8'd173, 8'd255};
        4'd13:   p = '{8'd131, 8'd118, 8'd156};
        4'd14:   p = '{8'd255, 8'd119, 8'd168};
        4'd15:   p = '{8'd255, 8'd204, 8'd170};
        default: p = '{8'd0,   8'd0,   8'd0};
      endcase
      return p;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/hex_pixel_to_led_mapper.sv =====
// ----------------------------------------------------------------------------
// Hex pixel to LED mapper
// Turns a raster stream of hex-digit characters into LED writes with frame,
// physical strip index and palette color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The mapper takes one character per clock cycle while char_stall is low; the
// first register stage holds the source position, frame and decoded digit,
// the second holds the mapped LED index and palette color. The rate is set by
// the output handshake alone; a stall on the LED side holds both stages
// and is passed back as char_stall in the same cycle. A character with first
// set restarts the payload. Once the final pixel is written, characters are
// dropped until the next first. Configuration writes are always ready and
// take effect at once; they belong in idle periods.
module hex_pixel_to_led_mapper #(
  parameter int MATRIX_W = hpl_pkg::DEF_MATRIX_W,
  parameter int MATRIX_H = hpl_pkg::DEF_MATRIX_H
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Character channel.
  input  wire logic                           char_valid,
  output logic                                char_stall,
  input  wire logic [hpl_pkg::CHAR_W-1:0]     char_code,
  input  wire logic                           first,
  // LED write channel.
  output logic                                led_valid,
  input  wire logic                           led_stall,
  output logic [hpl_pkg::FRAME_W-1:0]         frame_number,
  output logic [hpl_pkg::LED_W-1:0]           led_index,
  output logic [hpl_pkg::COLOR_W-1:0]         red,
  output logic [hpl_pkg::COLOR_W-1:0]         green,
  output logic [hpl_pkg::COLOR_W-1:0]         blue,
  output logic                                last_pixel,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic                           cfg_data
);
  import hpl_pkg::*;

  localparam int CNT_W = POS_W + 1;
  localparam logic [CNT_W-1:0] W_C  = CNT_W'(MATRIX_W);
  localparam logic [CNT_W-1:0] H_C  = CNT_W'(MATRIX_H);
  localparam logic [CNT_W-1:0] W2_C = CNT_W'(2 * MATRIX_W);
  localparam logic [CNT_W-1:0] H2_C = CNT_W'(2 * MATRIX_H);
  localparam logic [COORD_W-1:0] WMAX_C = COORD_W'(MATRIX_W - 1);
  localparam logic [COORD_W-1:0] HMAX_C = COORD_W'(MATRIX_H - 1);
  localparam logic [LED_W:0] AREA_C = (LED_W + 1)'(MATRIX_W * MATRIX_H);

  // Configuration registers.
  logic col_mirror;
  logic row_mirror;
  logic serpentine;
  logic quadrant_mode;

  // Position state.
  logic [POS_W-1:0] source_column;
  logic [POS_W-1:0] source_row;
  logic             payload_done;

  // First stage registers.
  logic               s1_valid;
  logic [FRAME_W-1:0] s1_frame;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic [DIGIT_W-1:0] s1_digit;
  logic               s1_last;

  logic advance;
  logic accept;

  // The whole pipe moves whenever the output register can take a new value.
  assign advance    = !led_valid || !led_stall;
  assign char_stall = !advance;
  assign accept     = char_valid && advance;
  assign cfg_ready  = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_mirror    <= 1'b0;
      row_mirror    <= 1'b1;
      serpentine    <= 1'b1;
      quadrant_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FLIP_H:   col_mirror    <= cfg_data;
        REG_FLIP_V:   row_mirror    <= cfg_data;
        REG_SERPENT:  serpentine    <= cfg_data;
        REG_QUADRANT: quadrant_mode <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position tracking, frame split and digit decode for the accepted character.
  logic [CNT_W-1:0]   cols;
  logic [CNT_W-1:0]   rows;
  logic [CNT_W-1:0]   cur_col;
  logic [CNT_W-1:0]   cur_row;
  logic               cur_done;
  logic               in_range;
  logic               emit;
  logic [CNT_W-1:0]   col_inc;
  logic [CNT_W-1:0]   row_inc;
  logic [POS_W-1:0]   source_column_next;
  logic [POS_W-1:0]   source_row_next;
  logic               payload_done_next;
  logic               last_next;
  logic [FRAME_W-1:0] frame_next;
  logic [CNT_W-1:0]   x_full;
  logic [CNT_W-1:0]   y_full;

  always_comb begin
    cols     = quadrant_mode ? W2_C : W_C;
    rows     = quadrant_mode ? H2_C : H_C;
    cur_col  = first ? '0 : {1'b0, source_column};
    cur_row  = first ? '0 : {1'b0, source_row};
    cur_done = first ? 1'b0 : payload_done;
    in_range = (cur_col < cols) && (cur_row < rows);
    emit     = !cur_done && in_range;

    col_inc = cur_col + 1'b1;
    row_inc = cur_row + 1'b1;
    source_column_next = cur_col[POS_W-1:0];
    source_row_next    = cur_row[POS_W-1:0];
    payload_done_next  = cur_done || !in_range;
    last_next          = 1'b0;
    if (emit) begin
      if (col_inc >= cols) begin
        source_column_next = '0;
        if (row_inc >= rows) begin
          source_row_next   = '0;
          payload_done_next = 1'b1;
          last_next         = 1'b1;
        end else begin
          source_row_next = row_inc[POS_W-1:0];
        end
      end else begin
        source_column_next = col_inc[POS_W-1:0];
      end
    end

    // Quadrant split: bottom half adds two, right half adds one.
    x_full     = cur_col;
    y_full     = cur_row;
    frame_next = '0;
    if (quadrant_mode) begin
      if (cur_row >= H_C) begin
        frame_next[1] = 1'b1;
        y_full        = cur_row - H_C;
      end
      if (cur_col >= W_C) begin
        frame_next[0] = 1'b1;
        x_full        = cur_col - W_C;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
      payload_done  <= 1'b0;
    end else if (accept) begin
      source_column <= source_column_next;
      source_row    <= source_row_next;
      payload_done  <= payload_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_frame <= frame_next;
      s1_x     <= x_full[COORD_W-1:0];
      s1_y     <= y_full[COORD_W-1:0];
      s1_digit <= decode_digit(char_code);
      s1_last  <= last_next;
    end
  end

  // Mirror, serpentine order and palette lookup.
  logic [COORD_W-1:0] xm;
  logic [COORD_W-1:0] ym;
  logic [COORD_W-1:0] xs;
  logic [LED_W:0]     led_sum;
  logic [LED_W-1:0]   led_next;
  rgb_t               color;

  always_comb begin
    xm = col_mirror ? (WMAX_C - s1_x) : s1_x;
    ym = row_mirror ? (HMAX_C - s1_y) : s1_y;
    xs = (serpentine && ym[0]) ? (WMAX_C - xm) : xm;
    led_sum = (LED_W + 1)'(ym) * (LED_W + 1)'(MATRIX_W) + (LED_W + 1)'(xs);
    led_next = (led_sum >= AREA_C) ? '0 : led_sum[LED_W-1:0];
    color = palette(s1_digit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= 1'b0;
    end else if (advance) begin
      led_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_number <= s1_frame;
      led_index    <= led_next;
      red          <= color.r;
      green        <= color.g;
      blue         <= color.b;
      last_pixel   <= s1_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpl_checker.sv =====
// ----------------------------------------------------------------------------
// Hex pixel LED mapper checker
// Port-level assertions for the mapper, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpl_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           char_stall,
  input wire logic                           led_valid,
  input wire logic                           led_stall,
  input wire logic [hpl_pkg::FRAME_W-1:0]    frame_number,
  input wire logic [hpl_pkg::LED_W-1:0]      led_index,
  input wire logic [hpl_pkg::COLOR_W-1:0]    red,
  input wire logic [hpl_pkg::COLOR_W-1:0]    green,
  input wire logic [hpl_pkg::COLOR_W-1:0]    blue,
  input wire logic                           last_pixel,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  // Reset leaves no LED write pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !led_valid)
    else $error("LED write pending after reset");

  // The character side stalls only when a finished write is held back.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (led_valid && led_stall))
    else $error("character stall without a held LED write");

  // A held LED write stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (led_valid && led_stall) |=> led_valid)
    else $error("LED write dropped while stalled");

  // A held LED write keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (led_valid && led_stall) |=> ($stable(frame_number) && $stable(led_index) &&
      $stable(red) && $stable(green) && $stable(blue) && $stable(last_pixel)))
    else $error("LED write payload changed while stalled");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind hex_pixel_to_led_mapper hpl_checker u_hpl_checker (
  .clk          (clk),
  .rst          (rst),
  .char_stall   (char_stall),
  .led_valid    (led_valid),
  .led_stall    (led_stall),
  .frame_number (frame_number),
  .led_index    (led_index),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .last_pixel   (last_pixel),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
